[sv/word_censor_filter_assert.svh]
// ----------------------------------------------------------------------------
// word censor filter assertion macros
// shared property forms for the filter rtl
// ----------------------------------------------------------------------------
`ifndef WORD_CENSOR_FILTER_ASSERT_SVH
`define WORD_CENSOR_FILTER_ASSERT_SVH

// invariant checked at every clock edge outside reset
`define WCF_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define WCF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/wcf_pkg.sv]
// ----------------------------------------------------------------------------
// wcf_pkg
// shared types, constants and helpers of the word censor filter
// ----------------------------------------------------------------------------
package wcf_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT      = 3'd4;

   localparam logic [63:0] PATTERN_BYTES_RESET = 64'd35;
   localparam logic [3:0]  PATTERN_LENGTH_RESET = 4'd1;
   localparam logic [63:0] REPLACEMENT_BYTES_RESET = 64'd0;
   localparam logic [3:0]  REPLACEMENT_LENGTH_RESET = 4'd0;
   localparam logic [11:0] OUTPUT_LIMIT_RESET = 12'd511;

   localparam logic [3:0] REPLACEMENT_MAX = 4'd8;
   localparam logic [7:0] SEPARATOR  = 8'd32;
   localparam logic [7:0] UPPER_A    = 8'd65;
   localparam logic [7:0] UPPER_Z    = 8'd90;
   localparam logic [7:0] CASE_SHIFT = 8'd32;

   // matcher control from the sequencer
   typedef struct packed {
      logic       step;
      logic       clear;
      logic [7:0] data;
      logic       seen_ok;
   } match_ctl_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_SHIFT;
      end
      return r;
   endfunction

endpackage

[sv/wcf_req_if.sv]
// ----------------------------------------------------------------------------
// wcf_req_if
// input byte channel of the word censor filter
// ----------------------------------------------------------------------------
interface wcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       line_end;

   modport source (output valid, output in_byte, output line_end, input ready);
   modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

[sv/wcf_rsp_if.sv]
// ----------------------------------------------------------------------------
// wcf_rsp_if
// filtered output channel of the word censor filter
// ----------------------------------------------------------------------------
interface wcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last_of_line;
   logic       line_censored;
   logic       word_overflow;

   modport source (output valid, output out_byte, output byte_valid, output last_of_line,
                   output line_censored, output word_overflow, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input last_of_line,
                 input line_censored, input word_overflow, output ready);
endinterface

[sv/wcf_csr_if.sv]
// ----------------------------------------------------------------------------
// wcf_csr_if
// register write channel of the word censor filter
// ----------------------------------------------------------------------------
interface wcf_csr_if;
   import wcf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/word_censor_filter.sv]
// ----------------------------------------------------------------------------
// word_censor_filter
// per-word pattern censor over a byte stream of text lines
// ----------------------------------------------------------------------------
// req_if carries one text byte per beat, line_end set on the last byte of a
// line. rsp_if returns the filtered bytes, then one bare end marker per line
// with last_of_line set and line_censored telling whether a word was replaced.
// csr_if writes pattern, replacement and the output limit; the user is to
// write them only while idle; the block itself does not enforce it.
// a non-space byte inside a line is written to the word ram while it has
// room and shifted into the match window. a space or line end flushes the
// word: each byte is read from the ram and loaded into the output register,
// or on a hit the replacement bytes are sent; a space or end marker follows.
// rsp_if is held by an output register; a stalled receiver holds the flush at
// the current byte and the input channel stays not ready until it is done.
// reset returns the registers to their defaults and clears the word and line
// state; the word ram needs no clearing since only filled entries are read.
// ----------------------------------------------------------------------------
`include "word_censor_filter_assert.svh"

module word_censor_filter #(
   parameter int WORD_DEPTH  = 32,
   parameter int PATTERN_MAX = 8
) (
   input  logic     clock,
   input  logic     reset,
   wcf_req_if.sink  req_if,
   wcf_rsp_if.source rsp_if,
   wcf_csr_if.sink  csr_if
);
   import wcf_pkg::*;

   localparam int AW = $clog2(WORD_DEPTH);
   localparam int FW = $clog2(WORD_DEPTH + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EMIT, ST_SEP, ST_MARK} state_type;

   state_type     state_ff, state_in;
   logic [63:0]   pattern_ff, pattern_in;
   logic [3:0]    pat_len_ff, pat_len_in;
   logic [63:0]   repl_ff, repl_in;
   logic [3:0]    repl_len_ff, repl_len_in;
   logic [11:0]   limit_ff, limit_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [11:0]   emitted_ff, emitted_in;
   logic          any_ff, any_in;
   logic          ovf_ff, ovf_in;
   logic          sep_ff, sep_in;
   logic          end_ff, end_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_bval_ff, rsp_bval_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_cens_ff, rsp_cens_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   match_ctl_type mctl;
   logic          hit;
   logic          ram_we, ram_re;
   logic [7:0]    ram_q;
   logic [3:0]    pat_len_eff, repl_len_eff;
   logic [FW:0]   seen;
   logic          seen_ok;
   logic [FW-1:0] word_cnt;
   logic [7:0]    byte_sel;
   logic          emit_ok, limit_hit, in_sep;

   wcf_ram #(.WIDTH(8), .DEPTH(WORD_DEPTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_if.in_byte),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   wcf_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mctl),
      .pattern (pattern_ff[8*PATTERN_MAX-1:0]),
      .pat_len (pat_len_eff),
      .hit     (hit)
   );

   assign pat_len_eff  = (pat_len_ff == 4'd0) ? 4'd1 :
                         (pat_len_ff > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : pat_len_ff;
   assign repl_len_eff = (repl_len_ff > REPLACEMENT_MAX) ? REPLACEMENT_MAX : repl_len_ff;
   assign seen         = (fill_ff < FW'(WORD_DEPTH)) ? ({1'b0, fill_ff} + (FW+1)'(1))
                                                     : (FW+1)'(WORD_DEPTH);
   assign seen_ok      = seen >= (FW+1)'(pat_len_eff);
   assign word_cnt     = hit ? FW'(repl_len_eff) : fill_ff;
   assign byte_sel     = hit ? repl_ff[8*idx_ff[2:0] +: 8] : ram_q;
   assign emit_ok      = !rsp_valid_ff || rsp_if.ready;
   assign limit_hit    = emitted_ff >= limit_ff;
   assign in_sep       = req_if.in_byte == SEPARATOR;

   assign req_if.ready = state_ff == ST_IDLE;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.out_byte      = rsp_byte_ff;
   assign rsp_if.byte_valid    = rsp_bval_ff;
   assign rsp_if.last_of_line  = rsp_last_ff;
   assign rsp_if.line_censored = rsp_cens_ff;
   assign rsp_if.word_overflow = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      pattern_in   = pattern_ff;
      pat_len_in   = pat_len_ff;
      repl_in      = repl_ff;
      repl_len_in  = repl_len_ff;
      limit_in     = limit_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      emitted_in   = emitted_ff;
      any_in       = any_ff;
      ovf_in       = ovf_ff;
      sep_in       = sep_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bval_in  = rsp_bval_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cens_in  = rsp_cens_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      mctl         = '0;

      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_PATTERN_BYTES:      pattern_in  = csr_if.data;
            CSR_PATTERN_LENGTH:     pat_len_in  = csr_if.data[3:0];
            CSR_REPLACEMENT_BYTES:  repl_in     = csr_if.data;
            CSR_REPLACEMENT_LENGTH: repl_len_in = csr_if.data[3:0];
            CSR_OUTPUT_LIMIT:       limit_in    = csr_if.data[11:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (!in_sep) begin
                  mctl.step    = 1'b1;
                  mctl.data    = req_if.in_byte;
                  mctl.seen_ok = seen_ok;
                  if (fill_ff < FW'(WORD_DEPTH)) begin
                     ram_we  = 1'b1;
                     fill_in = fill_ff + FW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (in_sep || req_if.line_end) begin
                  sep_in   = in_sep;
                  end_in   = req_if.line_end;
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (idx_ff < word_cnt) begin
               ram_re   = !hit;
               state_in = ST_EMIT;
            end else begin
               if (hit) begin
                  any_in = 1'b1;
               end
               state_in = sep_ff ? ST_SEP : ST_MARK;
            end
         end
         ST_EMIT: begin
            if (limit_hit) begin
               idx_in   = idx_ff + FW'(1);
               state_in = ST_READ;
            end else if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_sel;
               rsp_bval_in  = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_cens_in  = 1'b0;
               rsp_ovf_in   = ovf_ff;
               emitted_in   = emitted_ff + 12'd1;
               idx_in       = idx_ff + FW'(1);
               state_in     = ST_READ;
            end
         end
         ST_SEP: begin
            if (limit_hit || emit_ok) begin
               if (!limit_hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = SEPARATOR;
                  rsp_bval_in  = 1'b1;
                  rsp_last_in  = 1'b0;
                  rsp_cens_in  = 1'b0;
                  rsp_ovf_in   = ovf_ff;
                  emitted_in   = emitted_ff + 12'd1;
               end
               if (end_ff) begin
                  state_in = ST_MARK;
               end else begin
                  fill_in    = '0;
                  ovf_in     = 1'b0;
                  mctl.clear = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_MARK: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'd0;
               rsp_bval_in  = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_cens_in  = any_ff;
               rsp_ovf_in   = ovf_ff;
               emitted_in   = '0;
               any_in       = 1'b0;
               fill_in      = '0;
               ovf_in       = 1'b0;
               mctl.clear   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pattern_ff   <= PATTERN_BYTES_RESET;
         pat_len_ff   <= PATTERN_LENGTH_RESET;
         repl_ff      <= REPLACEMENT_BYTES_RESET;
         repl_len_ff  <= REPLACEMENT_LENGTH_RESET;
         limit_ff     <= OUTPUT_LIMIT_RESET;
         fill_ff      <= '0;
         idx_ff       <= '0;
         emitted_ff   <= '0;
         any_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         sep_ff       <= 1'b0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pattern_ff   <= pattern_in;
         pat_len_ff   <= pat_len_in;
         repl_ff      <= repl_in;
         repl_len_ff  <= repl_len_in;
         limit_ff     <= limit_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         emitted_ff   <= emitted_in;
         any_ff       <= any_in;
         ovf_ff       <= ovf_in;
         sep_ff       <= sep_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_bval_ff <= rsp_bval_in;
      rsp_last_ff <= rsp_last_in;
      rsp_cens_ff <= rsp_cens_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   `WCF_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FW'(WORD_DEPTH), "word fill past depth")
   `WCF_ASSERT_IMPLY(a_emit_index, clock, reset, state_ff == ST_EMIT, idx_ff < word_cnt, "emit index past word")
   `WCF_ASSERT_NEXT(a_line_cleared, clock, reset, state_ff == ST_MARK && emit_ok, state_ff == ST_IDLE && fill_ff == '0 && !any_ff && emitted_ff == '0, "line state not cleared after end marker")
endmodule

[sv/wcf_ram.sv]
// ----------------------------------------------------------------------------
// wcf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/wcf_match.sv]
// ----------------------------------------------------------------------------
// wcf_match
// case-folded window of recent word bytes and pattern hit flag
// ----------------------------------------------------------------------------
module wcf_match #(
   parameter int PATTERN_MAX = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wcf_pkg::match_ctl_type     ctl,
   input  logic [8*PATTERN_MAX-1:0]   pattern,
   input  logic [3:0]                 pat_len,
   output logic                       hit
);
   import wcf_pkg::*;

   localparam int WW = 8 * PATTERN_MAX;

   logic [WW-1:0] window_ff, window_in;
   logic          hit_ff, hit_in;
   logic          match;

   always_comb begin
      logic [3:0] j;
      window_in = (window_ff << 8) | WW'(fold_case(ctl.data));
      match = ctl.seen_ok;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         j = pat_len - 4'd1 - 4'(i);
         if (4'(i) < pat_len) begin
            if (fold_case(pattern[8*i +: 8]) != window_in[8*j +: 8]) begin
               match = 1'b0;
            end
         end
      end
      hit_in = hit_ff;
      if (ctl.clear) begin
         window_in = '0;
         hit_in    = 1'b0;
      end else if (ctl.step) begin
         hit_in = hit_ff | match;
      end else begin
         window_in = window_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         window_ff <= window_in;
         hit_ff    <= hit_in;
      end
   end

   assign hit = hit_ff;
endmodule
